// File: hw/rtl/prv_pkg.sv
// shared constants, byte codes and event types of the pipe record validator
package prv_pkg;

  localparam int LINE_BITS = 24;
  localparam int PIPE_BITS = 16;
  localparam int ID_BITS   = 63;
  localparam int CNT_BITS  = 24;
  localparam int EXP_BITS  = 16;

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [PIPE_BITS-1:0] PIPE_MAX = '1;
  localparam logic [CNT_BITS-1:0]  CNT_MAX  = '1;

  localparam logic [EXP_BITS-1:0] EXP_RESET = EXP_BITS'(2);

  localparam logic [7:0] CH_PIPE = 8'h7C;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] BOM_B0  = 8'hEF;
  localparam logic [7:0] BOM_B1  = 8'hBB;
  localparam logic [7:0] BOM_B2  = 8'hBF;

  localparam logic KIND_TEXT = 1'b0;

  // event queue between parser and record tracker
  localparam int QDEPTH    = 4;
  localparam int QIDX_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // one classified event: extend the open record to a line, count a pipe,
  // open a new record, or finish the text
  typedef struct packed {
    logic                 ext;
    logic                 pipe;
    logic                 open;
    logic                 fin;
    logic [ID_BITS-1:0]   id;
    logic [LINE_BITS-1:0] line;
  } prv_ev_t;

  typedef struct packed {
    logic    push;
    prv_ev_t ev;
  } prv_push_t;

  typedef struct packed {
    logic    avail;
    prv_ev_t ev;
  } prv_head_t;

endpackage

// File: hw/rtl/prv_if.sv
// valid/ready channels for text beats in and record results out
interface prv_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface prv_out_if;
  import prv_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 record_present;
  logic [ID_BITS-1:0]   record_id;
  logic [LINE_BITS-1:0] start_line;
  logic [LINE_BITS-1:0] end_line;
  logic [PIPE_BITS-1:0] pipe_count;
  logic                 record_valid;
  logic                 is_final;
  logic [CNT_BITS-1:0]  record_total;
  logic [CNT_BITS-1:0]  valid_total;
  logic                 has_last_good_id;
  logic [ID_BITS-1:0]   last_good_id;

  modport source (
    output valid, output record_present, output record_id, output start_line,
    output end_line, output pipe_count, output record_valid, output is_final,
    output record_total, output valid_total, output has_last_good_id,
    output last_good_id, input ready
  );
  modport sink (
    input valid, input record_present, input record_id, input start_line,
    input end_line, input pipe_count, input record_valid, input is_final,
    input record_total, input valid_total, input has_last_good_id,
    input last_good_id, output ready
  );
endinterface

// File: hw/rtl/prv_front.sv
// line parser: tracks line phase, bom, id digits and line number, emits events
module prv_front (
  input  logic              clk,
  input  logic              rst_n,
  prv_in_if.sink            in_ch,
  input  logic              q_full,
  output prv_pkg::prv_push_t push
);
  import prv_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_BOM1, PH_BOM2, PH_AFTER_BOM, PH_DIGITS, PH_PLAIN, PH_RECORD
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [ID_BITS-1:0]   acc_r, acc_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 accept;
  logic                 is_digit;
  logic                 is_pipe;
  logic [3:0]           digit;
  logic [ID_BITS+3:0]   acc_wide;
  logic [ID_BITS+3:0]   acc_sum;
  prv_ev_t              ev;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign is_digit    = (in_ch.text_byte >= CH_ZERO) && (in_ch.text_byte <= CH_NINE);
  assign is_pipe     = (in_ch.text_byte == CH_PIPE);
  assign digit       = 4'(in_ch.text_byte - CH_ZERO);
  assign acc_wide    = (ID_BITS+4)'(acc_r);
  // acc * 10 + digit, overflow when it leaves 63 bits
  assign acc_sum     = (acc_wide << 3) + (acc_wide << 1) + (ID_BITS+4)'(digit);

  always_comb begin
    phase_nxt = phase_r;
    line_nxt  = line_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    ev        = '0;
    ev.id     = acc_r;
    ev.line   = line_r;
    if (in_ch.kind != KIND_TEXT) begin
      ev.fin    = 1'b1;
      ev.ext    = (phase_r == PH_BOM1) || (phase_r == PH_BOM2) ||
                  (phase_r == PH_AFTER_BOM) || (phase_r == PH_DIGITS);
      phase_nxt = PH_START;
      line_nxt  = LINE_BITS'(1);
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else if (in_ch.text_byte == CH_NL) begin
      ev.ext    = (phase_r != PH_PLAIN) && (phase_r != PH_RECORD);
      if (line_r != LINE_MAX) begin
        line_nxt = line_r + LINE_BITS'(1);
      end
      phase_nxt = PH_START;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_START, PH_AFTER_BOM: begin
          if (phase_r == PH_START && in_ch.text_byte == BOM_B0) begin
            phase_nxt = PH_BOM1;
          end else if (is_digit) begin
            acc_nxt   = ID_BITS'(digit);
            ovf_nxt   = 1'b0;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_PLAIN;
            ev.ext    = 1'b1;
            ev.pipe   = is_pipe;
          end
        end
        PH_BOM1: begin
          if (in_ch.text_byte == BOM_B1) begin
            phase_nxt = PH_BOM2;
          end else begin
            phase_nxt = PH_PLAIN;
            ev.ext    = 1'b1;
            ev.pipe   = is_pipe;
          end
        end
        PH_BOM2: begin
          if (in_ch.text_byte == BOM_B2) begin
            phase_nxt = PH_AFTER_BOM;
          end else begin
            phase_nxt = PH_PLAIN;
            ev.ext    = 1'b1;
            ev.pipe   = is_pipe;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (!ovf_r) begin
              if (|acc_sum[ID_BITS+3:ID_BITS]) begin
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = acc_sum[ID_BITS-1:0];
              end
            end
          end else if (is_pipe && !ovf_r) begin
            ev.open   = 1'b1;
            phase_nxt = PH_RECORD;
          end else begin
            phase_nxt = PH_PLAIN;
            ev.ext    = 1'b1;
            ev.pipe   = is_pipe;
          end
        end
        default: begin
          ev.pipe = is_pipe;
        end
      endcase
    end
  end

  assign push.push = accept && (ev.ext || ev.pipe || ev.open || ev.fin);
  assign push.ev   = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      line_r  <= LINE_BITS'(1);
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// File: hw/rtl/prv_queue.sv
// short event queue that decouples the parser from the record tracker
module prv_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  prv_pkg::prv_push_t push,
  output logic               full,
  output prv_pkg::prv_head_t head,
  input  logic               pop
);
  import prv_pkg::*;

  prv_ev_t              mem_r [QDEPTH];
  logic [QIDX_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count_r == QCNT_BITS'(QDEPTH));
  assign head.avail = (count_r != '0);
  assign head.ev    = mem_r[rd_ptr_r];
  assign do_push    = push.push && !full;
  assign do_pop     = pop && head.avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QIDX_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QIDX_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_BITS'(1);
      end
    end
  end

endmodule

// File: hw/rtl/prv_back.sv
// record tracker: applies events to the open record and totals, drives results
module prv_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [prv_pkg::EXP_BITS-1:0]   cfg_wdata,
  input  prv_pkg::prv_head_t             head,
  output logic                           pop,
  prv_out_if.source                      out_ch
);
  import prv_pkg::*;

  logic [EXP_BITS-1:0]  expected_r;

  logic                 has_r, has_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [LINE_BITS-1:0] start_r, start_nxt;
  logic [LINE_BITS-1:0] end_r, end_nxt;
  logic [PIPE_BITS-1:0] pipes_r, pipes_nxt;
  logic                 err_r, err_nxt;
  logic [CNT_BITS-1:0]  nrec_r, nrec_nxt;
  logic [CNT_BITS-1:0]  nval_r, nval_nxt;
  logic                 good_r, good_nxt;
  logic [ID_BITS-1:0]   good_id_r, good_id_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 emits;
  logic                 slot_free;
  logic                 rec_ok;
  logic [LINE_BITS-1:0] end_eff;

  function automatic logic [CNT_BITS-1:0] nrec_nxt_tot(input logic inc,
                                                       input logic [CNT_BITS-1:0] cnt);
    logic [CNT_BITS-1:0] res;
    res = cnt;
    if (inc && cnt != CNT_MAX) begin
      res = cnt + CNT_BITS'(1);
    end
    return res;
  endfunction

  assign emits     = head.avail && (head.ev.fin || (head.ev.open && has_r));
  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop       = head.avail && (!emits || slot_free);
  assign rec_ok    = has_r && (pipes_r == expected_r);
  // on end of text the pending line may still extend the record
  assign end_eff   = (head.ev.ext && has_r) ? head.ev.line : end_r;

  always_comb begin
    has_nxt       = has_r;
    id_nxt        = id_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    pipes_nxt     = pipes_r;
    err_nxt       = err_r;
    nrec_nxt      = nrec_r;
    nval_nxt      = nval_r;
    good_nxt      = good_r;
    good_id_nxt   = good_id_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (pop) begin
      // totals of the record being finished
      if (emits && has_r) begin
        if (nrec_r != CNT_MAX) begin
          nrec_nxt = nrec_r + CNT_BITS'(1);
        end
        if (rec_ok) begin
          if (nval_r != CNT_MAX) begin
            nval_nxt = nval_r + CNT_BITS'(1);
          end
          if (!err_r) begin
            good_nxt    = 1'b1;
            good_id_nxt = id_r;
          end
        end else begin
          err_nxt = 1'b1;
        end
      end

      if (emits) begin
        out_valid_nxt = 1'b1;
      end

      if (head.ev.fin) begin
        has_nxt     = 1'b0;
        id_nxt      = '0;
        start_nxt   = '0;
        end_nxt     = '0;
        pipes_nxt   = '0;
        err_nxt     = 1'b0;
        nrec_nxt    = '0;
        nval_nxt    = '0;
        good_nxt    = 1'b0;
        good_id_nxt = '0;
      end else if (head.ev.open) begin
        has_nxt   = 1'b1;
        id_nxt    = head.ev.id;
        start_nxt = head.ev.line;
        end_nxt   = head.ev.line;
        pipes_nxt = PIPE_BITS'(1);
      end else begin
        end_nxt = end_eff;
        if (head.ev.pipe && has_r && pipes_r != PIPE_MAX) begin
          pipes_nxt = pipes_r + PIPE_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= EXP_RESET;
      has_r       <= 1'b0;
      id_r        <= '0;
      start_r     <= '0;
      end_r       <= '0;
      pipes_r     <= '0;
      err_r       <= 1'b0;
      nrec_r      <= '0;
      nval_r      <= '0;
      good_r      <= 1'b0;
      good_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        expected_r <= cfg_wdata;
      end
      has_r       <= has_nxt;
      id_r        <= id_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      pipes_r     <= pipes_nxt;
      err_r       <= err_nxt;
      nrec_r      <= nrec_nxt;
      nval_r      <= nval_nxt;
      good_r      <= good_nxt;
      good_id_r   <= good_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded when a finishing beat leaves the queue
  always_ff @(posedge clk) begin
    if (pop && emits) begin
      out_ch.record_present   <= has_r;
      out_ch.record_id        <= has_r ? id_r : '0;
      out_ch.start_line       <= has_r ? start_r : '0;
      out_ch.end_line         <= has_r ? end_eff : '0;
      out_ch.pipe_count       <= has_r ? pipes_r : '0;
      out_ch.record_valid     <= rec_ok;
      out_ch.is_final         <= head.ev.fin;
      out_ch.record_total     <= nrec_nxt_tot(has_r, nrec_r);
      out_ch.valid_total      <= nrec_nxt_tot(rec_ok, nval_r);
      out_ch.has_last_good_id <= (rec_ok && !err_r) || good_r;
      out_ch.last_good_id     <= (rec_ok && !err_r) ? id_r : good_id_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

// File: hw/rtl/pipe_record_validator.sv
// top level of the pipe record validator: parser, event queue, record tracker
//
// in_ch carries one text beat per cycle while ready: kind 0 with a text
// byte, kind 1 for end of text. out_ch carries result beats: one when a new
// record opens while another is open (the finished record), and one for every
// end-of-text beat (the last record if any, plus running totals and the last
// good id). cfg_we/cfg_wdata write the expected pipe count; write it only
// while idle.
// throughput: one text beat per cycle while the event queue has room, set by
// the line parser and the record tracker. An accepted beat goes into the
// 4-entry event queue, then through the tracker into the output register.
//
// reset (rst_n low, synchronous) clears the parser, queue and tracker and sets
// the expected pipe count to 2. end of text clears all state but that count.
// when out_ch stalls, the tracker holds its result and stops at the next result
// event; the queue fills to four events, then in_ch.ready drops until taken.
module pipe_record_validator (
  input  logic                         clk,
  input  logic                         rst_n,
  prv_in_if.sink                       in_ch,
  prv_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [prv_pkg::EXP_BITS-1:0] cfg_wdata
);
  import prv_pkg::*;

  prv_push_t push;
  prv_head_t head;
  logic      q_full;
  logic      pop;

  prv_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  prv_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  prv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// File: sim/prv_checker.sv
// checker for the pipe record validator: predicts record results from text beats and compares
module prv_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  prv_in_if                            in_ch,
  prv_out_if                           out_ch,
  input  logic                         cfg_we,
  input  logic [prv_pkg::EXP_BITS-1:0] cfg_wdata,
  output int                           fail_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import prv_pkg::*;

  localparam logic [63:0] ID_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    PH_START, PH_BOM1, PH_BOM2, PH_AFTER_BOM, PH_DIGITS, PH_PLAIN, PH_RECORD
  } line_phase_t;

  typedef struct packed {
    logic                 present;
    logic [ID_BITS-1:0]   id;
    logic [LINE_BITS-1:0] first_line;
    logic [LINE_BITS-1:0] last_line;
    logic [PIPE_BITS-1:0] pipes;
    logic                 ok;
    logic                 fin;
    logic [CNT_BITS-1:0]  n_records;
    logic [CNT_BITS-1:0]  n_valid;
    logic                 good_flag;
    logic [ID_BITS-1:0]   good_id;
  } rec_result_t;

  logic [EXP_BITS-1:0]  exp_pipes;
  logic [LINE_BITS-1:0] line_no;
  line_phase_t          phase;
  logic [63:0]          id_acc;
  logic                 id_ovf;
  logic                 rec_open;
  logic [ID_BITS-1:0]   rec_id;
  logic [LINE_BITS-1:0] rec_first;
  logic [LINE_BITS-1:0] rec_last;
  logic [PIPE_BITS-1:0] rec_pipes;
  logic                 err_seen;
  logic [CNT_BITS-1:0]  n_records;
  logic [CNT_BITS-1:0]  n_valid;
  logic                 good_flag;
  logic [ID_BITS-1:0]   good_id;

  rec_result_t expected_records[$];

  function automatic void clear_text();
    line_no   = LINE_BITS'(1);
    phase     = PH_START;
    id_acc    = '0;
    id_ovf    = 1'b0;
    rec_open  = 1'b0;
    rec_id    = '0;
    rec_first = '0;
    rec_last  = '0;
    rec_pipes = '0;
    err_seen  = 1'b0;
    n_records = '0;
    n_valid   = '0;
    good_flag = 1'b0;
    good_id   = '0;
  endfunction

  function automatic void mark_line();
    if (rec_open) rec_last = line_no;
  endfunction

  function automatic void count_pipe();
    if (rec_open && rec_pipes != PIPE_MAX) rec_pipes++;
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    phase = PH_PLAIN;
    mark_line();
    if (b == CH_PIPE) count_pipe();
  endfunction

  // finishes the open record, if any, and builds the result beat
  function automatic rec_result_t close_record(input logic fin);
    rec_result_t r;
    logic ok;
    r  = '0;
    ok = 1'b0;
    if (rec_open) begin
      ok = (PIPE_BITS'(rec_pipes) == PIPE_BITS'(exp_pipes));
      if (n_records != CNT_MAX) n_records++;
      if (ok) begin
        if (n_valid != CNT_MAX) n_valid++;
        if (!err_seen) begin
          good_flag = 1'b1;
          good_id   = rec_id;
        end
      end else begin
        err_seen = 1'b1;
      end
      r.present    = 1'b1;
      r.id         = rec_id;
      r.first_line = rec_first;
      r.last_line  = rec_last;
      r.pipes      = rec_pipes;
    end
    r.ok        = ok;
    r.fin       = fin;
    r.n_records = n_records;
    r.n_valid   = n_valid;
    r.good_flag = good_flag;
    r.good_id   = good_flag ? good_id : '0;
    return r;
  endfunction

  function automatic logic predict_beat(input logic kind, input logic [7:0] b,
                                        output rec_result_t r);
    logic        got;
    logic        digit;
    logic        line_head;
    logic [63:0] d;
    got = 1'b0;
    r   = '0;
    if (kind != KIND_TEXT) begin
      if (phase >= PH_BOM1 && phase <= PH_DIGITS) mark_line();
      r = close_record(1'b1);
      clear_text();
      return 1'b1;
    end
    if (b == CH_NL) begin
      if (phase <= PH_DIGITS) mark_line();
      if (line_no != LINE_MAX) line_no++;
      phase  = PH_START;
      id_acc = '0;
      id_ovf = 1'b0;
      return 1'b0;
    end
    digit     = (b >= CH_ZERO && b <= CH_NINE);
    d         = 64'(b - CH_ZERO);
    line_head = 1'b0;
    case (phase)
      PH_START: begin
        if (b == BOM_B0) phase = PH_BOM1;
        else line_head = 1'b1;
      end
      PH_BOM1: begin
        if (b == BOM_B1) phase = PH_BOM2;
        else plain_byte(b);
      end
      PH_BOM2: begin
        if (b == BOM_B2) phase = PH_AFTER_BOM;
        else plain_byte(b);
      end
      PH_AFTER_BOM: line_head = 1'b1;
      PH_DIGITS: begin
        if (digit) begin
          if (!id_ovf) begin
            if (id_acc > (ID_LIMIT - d) / 64'd10) id_ovf = 1'b1;
            else id_acc = id_acc * 64'd10 + d;
          end
        end else if (b == CH_PIPE && !id_ovf) begin
          // opening pipe: finish the previous record, start a new one
          got = rec_open;
          if (rec_open) r = close_record(1'b0);
          rec_open  = 1'b1;
          rec_id    = id_acc[ID_BITS-1:0];
          rec_first = line_no;
          rec_last  = line_no;
          rec_pipes = PIPE_BITS'(1);
          phase     = PH_RECORD;
        end else begin
          plain_byte(b);
        end
      end
      default: begin
        if (b == CH_PIPE) count_pipe();
      end
    endcase
    if (line_head) begin
      if (digit) begin
        id_acc = d;
        id_ovf = 1'b0;
        phase  = PH_DIGITS;
      end else begin
        plain_byte(b);
      end
    end
    return got;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    rec_result_t want;
    rec_result_t next_rec;
    if (!rst_n) begin
      exp_pipes = EXP_RESET;
      clear_text();
      expected_records.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_records.size() == 0) begin
          $error("result beat with no record expected");
          fail_count++;
        end else begin
          want = expected_records.pop_front();
          check_field("record_present", 64'(want.present), 64'(out_ch.record_present));
          check_field("record_id", 64'(want.id), 64'(out_ch.record_id));
          check_field("start_line", 64'(want.first_line), 64'(out_ch.start_line));
          check_field("end_line", 64'(want.last_line), 64'(out_ch.end_line));
          check_field("pipe_count", 64'(want.pipes), 64'(out_ch.pipe_count));
          check_field("record_valid", 64'(want.ok), 64'(out_ch.record_valid));
          check_field("is_final", 64'(want.fin), 64'(out_ch.is_final));
          check_field("record_total", 64'(want.n_records), 64'(out_ch.record_total));
          check_field("valid_total", 64'(want.n_valid), 64'(out_ch.valid_total));
          check_field("has_last_good_id", 64'(want.good_flag),
                      64'(out_ch.has_last_good_id));
          check_field("last_good_id", 64'(want.good_id), 64'(out_ch.last_good_id));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_beat(in_ch.kind, in_ch.text_byte, next_rec))
          expected_records.insert(expected_records.size(), next_rec);
      end
      if (cfg_we) exp_pipes = cfg_wdata;
    end
    pending = expected_records.size();
  end

endmodule

// File: sim/pipe_record_validator_tb.sv
// testbench top for the pipe record validator: text stimulus, idling phases and verdict
module pipe_record_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prv_pkg::*;

  localparam int          CYCLE_LIMIT  = 500_000;
  localparam int          PHASE_BEATS  = 275;
  localparam logic        KIND_END     = 1'b1;
  localparam logic [7:0]  CH_CR        = 8'h0D;
  localparam logic [7:0]  CH_FILL      = 8'h61;
  localparam logic [63:0] ID_LIMIT     = 64'h7FFF_FFFF_FFFF_FFFF;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [EXP_BITS-1:0] cfg_wdata;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int cycles     = 0;
  int beats_sent = 0;
  int exp_now    = 2;
  int fail_count;
  int pending;

  prv_in_if  in_ch ();
  prv_out_if out_ch ();

  pipe_record_validator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  prv_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[pipe_record_validator] ERROR");
      $finish;
    end
  end

  task automatic send_beat(input logic kind, input logic [7:0] b);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.text_byte <= b;
    taken = 1'b0;
    // ready is settled by the falling edge, so look there
    while (!taken) begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end
    beats_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_beat(KIND_TEXT, b);
  endtask

  task automatic put_number(input logic [63:0] v);
    logic [7:0] digs[20];
    int n;
    n = 0;
    do begin
      digs[n] = CH_ZERO + 8'(v % 64'd10);
      v = v / 64'd10;
      n++;
    end while (v != 0);
    for (int i = n - 1; i >= 0; i--) put_byte(digs[i]);
  endtask

  // any byte except pipe and newline
  task automatic put_field();
    logic [7:0] b;
    int n;
    n = $urandom_range(0, 4);
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_PIPE || b == CH_NL) b = CH_FILL;
      put_byte(b);
    end
  endtask

  task automatic end_line();
    if ($urandom_range(3) == 0) put_byte(CH_CR);
    put_byte(CH_NL);
  endtask

  task automatic put_id();
    case ($urandom_range(0, 15))
      0: put_number(ID_LIMIT);
      1: put_number(ID_LIMIT + 64'd1);
      2: begin
        // twenty or more digits with a nonzero lead always overflow
        put_byte(8'(CH_ZERO + $urandom_range(1, 9)));
        repeat ($urandom_range(19, 21)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      3: begin
        repeat ($urandom_range(1, 3)) put_byte(CH_ZERO);
        put_number(64'($urandom_range(0, 99)));
      end
      4: put_number({$urandom, $urandom} & ID_LIMIT);
      5: put_number(64'd0);
      default: put_number(64'($urandom_range(1, 999)));
    endcase
  endtask

  task automatic put_record_line();
    int n;
    if ($urandom_range(7) == 0) begin
      put_byte(BOM_B0);
      put_byte(BOM_B1);
      put_byte(BOM_B2);
    end
    put_id();
    put_byte(CH_PIPE);
    n = exp_now + $urandom_range(0, 4) - 2;
    if (n < 1) n = 1;
    for (int k = 1; k < n; k++) begin
      put_field();
      put_byte(CH_PIPE);
    end
    put_field();
    end_line();
  endtask

  task automatic put_other_line();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        put_field();
        if ($urandom_range(3) == 0) put_byte(CH_PIPE);
        put_field();
      end
      2: begin
        put_byte(BOM_B0);
        put_byte(8'($urandom_range(0, 255)) == CH_NL ? CH_PIPE : 8'($urandom_range(0, 255)));
        put_field();
      end
      3: begin
        put_byte(BOM_B0);
        put_byte(BOM_B1);
        b = 8'($urandom_range(0, 255));
        put_byte(b == CH_NL ? CH_PIPE : b);
        put_field();
      end
      4: begin
        // digit run that is not followed by a pipe
        put_number(64'($urandom_range(0, 9999)));
        b = 8'($urandom_range(0, 255));
        if (b == CH_PIPE || b == CH_NL || (b >= CH_ZERO && b <= CH_NINE)) b = CH_FILL;
        put_byte(b);
        put_field();
      end
      default: begin
        repeat ($urandom_range(1, 8)) begin
          b = 8'($urandom_range(0, 255));
          put_byte(b == CH_NL ? CH_PIPE : b);
        end
      end
    endcase
    end_line();
  endtask

  task automatic put_text();
    int lines;
    lines = $urandom_range(1, 8);
    repeat (lines) begin
      if ($urandom_range(9) < 7) put_record_line();
      else put_other_line();
    end
    case ($urandom_range(0, 3))
      1: put_number(64'($urandom_range(0, 99)));
      2: begin
        put_field();
        if ($urandom_range(1) == 0) put_byte(BOM_B0);
      end
      default: ;
    endcase
    send_beat(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_expected(input logic [EXP_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    exp_now = int'(v);
  endtask

  task automatic send_bytes(input logic [7:0] bytes[]);
    foreach (bytes[i]) put_byte(bytes[i]);
  endtask

  initial begin
    int start_beats;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_TEXT;
    in_ch.text_byte = 8'h00;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed text under the reset value of the expected count
    send_beat(KIND_END, 8'h00);
    send_bytes('{BOM_B0, BOM_B1, BOM_B2, CH_ZERO, CH_PIPE, CH_PIPE, CH_CR, CH_NL});
    send_bytes('{CH_NL, BOM_B0, CH_PIPE, CH_NL});
    send_bytes('{BOM_B0, BOM_B1, 8'h31, CH_PIPE, CH_NL});
    send_bytes('{8'h35, CH_PIPE, 8'hFF, 8'h00, CH_PIPE, CH_NL});
    send_beat(KIND_END, 8'hFF);
    wait_idle();

    // largest expected count, the record falls short of it
    set_expected(EXP_BITS'(65535));
    put_byte(8'h31);
    put_byte(CH_PIPE);
    repeat (24) put_byte(CH_PIPE);
    send_beat(KIND_END, 8'h00);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  set_expected(EXP_BITS'(1)); end
        1: begin idle_pct = 62; stall_pct = 0;  set_expected(EXP_BITS'(3)); end
        2: begin
          idle_pct = 0;
          stall_pct = 62;
          set_expected(EXP_BITS'($urandom_range(1, 6)));
        end
        default: begin idle_pct = 27; stall_pct = 27; set_expected(EXP_BITS'(2)); end
      endcase
      start_beats = beats_sent;
      while (beats_sent - start_beats < PHASE_BEATS) put_text();
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("[pipe_record_validator] OK");
    end else begin
      $display("[pipe_record_validator] ERROR");
    end
    $finish;
  end

endmodule

// File: pipe_record_validator.f
hw/rtl/prv_pkg.sv
hw/rtl/prv_if.sv
hw/rtl/prv_front.sv
hw/rtl/prv_queue.sv
hw/rtl/prv_back.sv
hw/rtl/pipe_record_validator.sv
sim/prv_checker.sv
sim/pipe_record_validator_tb.sv
